// File: src/htt_pkg.sv
package htt_pkg;

  // Sample and derived widths
  localparam int SAMPLE_W    = 24;
  localparam int SUM_W       = SAMPLE_W + 1;
  localparam int COEFF_W     = SAMPLE_W + 1;
  localparam int THR_W       = 25;
  localparam int CMP_W       = (COEFF_W > THR_W) ? COEFF_W : THR_W;
  localparam int COOL_W      = 8;
  localparam int WIN_W       = 10;
  localparam int BSF_W       = 11;
  localparam int KIND_W      = 2;

  // Stream packing
  localparam int IN_TDATA_W  = ((2 * SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((KIND_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = THR_W;

  localparam logic [CFG_IDX_W-1:0] REG_THR_LOW       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_HIGH      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP_COOL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW = 3'd4;

  // Register reset values
  localparam logic signed [THR_W-1:0] THR_LOW_RST   = 25'sd0;
  localparam logic signed [THR_W-1:0] THR_HIGH_RST  = 25'sd16777215;
  localparam logic [COOL_W-1:0]       COOLDOWN_RST  = 8'd40;
  localparam logic [COOL_W-1:0]       STARTUP_RST   = 8'd100;
  localparam logic [WIN_W-1:0]        WINDOW_RST    = 10'd130;

  // Saturation point of the elapsed-block counter
  localparam logic [BSF_W-1:0] BSF_MAX = {BSF_W{1'b1}};

  // Verdict codes
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DOUBLE = 2'd2;

  // Coefficient history count
  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_TWO  = 2'd2;

  typedef struct packed {
    logic signed [THR_W-1:0] thr_low;
    logic signed [THR_W-1:0] thr_high;
    logic [COOL_W-1:0]       cooldown_blocks;
    logic [WIN_W-1:0]        double_window;
    logic                    startup_load;
    logic [COOL_W-1:0]       startup_cooldown;
  } htt_cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] avg;
    logic                       block_end;
  } htt_item_t;

  typedef struct packed {
    logic blk_done;
    logic blk_peak;
  } htt_blk_t;

endpackage

// File: src/htt_avg_stage.sv
module htt_avg_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [htt_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                          in_tlast,
  input  logic                          out_hold,
  output htt_pkg::htt_item_t            item,
  output logic                          item_fire
);
  import htt_pkg::*;

  logic                       valid_r, valid_nxt;
  htt_item_t                  item_r;
  logic signed [SAMPLE_W-1:0] mic_a, mic_b;
  logic signed [SUM_W-1:0]    sum;
  logic                       in_xfer;

  // Average the two microphones: floor of half the sum
  assign mic_a = in_tdata[SAMPLE_W-1:0];
  assign mic_b = in_tdata[2*SAMPLE_W-1:SAMPLE_W];
  assign sum   = SUM_W'(mic_a) + SUM_W'(mic_b);

  // A block-end item waits only while the result register is full and out_tready is low
  assign item_fire = valid_r && (!item_r.block_end || !out_hold);
  assign in_tready = !valid_r || item_fire;
  assign in_xfer   = in_tvalid && in_tready;
  assign item      = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_xfer) begin
      valid_nxt = 1'b1;
    end else if (item_fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture the averaged pair on each input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.avg       <= sum[SUM_W-1:1];
      item_r.block_end <= in_tlast;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) !in_tready |-> valid_r)
    else $error("input stalled with an empty stage");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (valid_r && !item_r.block_end) |-> item_fire)
    else $error("non-final item held back");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (valid_r && !item_fire) |=> (valid_r && $stable(item_r)))
    else $error("held item changed");

endmodule

// File: src/htt_peak.sv
module htt_peak (
  input  logic                clk,
  input  logic                rst_n,
  input  htt_pkg::htt_cfg_t   cfg,
  input  htt_pkg::htt_item_t  item,
  input  logic                item_fire,
  output htt_pkg::htt_blk_t   blk
);
  import htt_pkg::*;

  logic signed [SAMPLE_W-1:0] even_r;
  logic                       phase_r, phase_nxt;
  logic signed [COEFF_W-1:0]  older_r, newer_r;
  logic signed [COEFF_W-1:0]  older_p, newer_p;
  logic [1:0]                 seen_r, seen_nxt, seen_p;
  logic                       peak_r, peak_nxt;
  logic signed [COEFF_W-1:0]  coeff;
  logic signed [CMP_W-1:0]    thr_lo, thr_hi, newer_x, newer_px;
  logic                       take, win_newer, win_newer_p;
  logic                       mid_peak, end_peak;

  // Detail coefficient: odd average minus even average
  assign coeff = COEFF_W'(item.avg) - COEFF_W'(even_r);
  assign take  = phase_r;

  assign thr_lo   = CMP_W'(cfg.thr_low);
  assign thr_hi   = CMP_W'(cfg.thr_high);
  assign newer_x  = CMP_W'(newer_r);
  assign newer_px = CMP_W'(newer_p);

  assign win_newer   = (newer_x >= thr_lo) && (newer_x <= thr_hi);
  assign win_newer_p = (newer_px >= thr_lo) && (newer_px <= thr_hi);

  // Newest coefficient becomes a peak once its right neighbour arrives; the first of a block needs no left one
  assign mid_peak = take && win_newer && (newer_r > coeff) &&
                    ((seen_r == SEEN_ONE) ||
                     ((seen_r == SEEN_TWO) && (newer_r > older_r)));

  // Shift the coefficient history
  assign newer_p = take ? coeff : newer_r;
  assign older_p = take ? newer_r : older_r;
  assign seen_p  = (take && (seen_r != SEEN_TWO)) ? seen_r + 2'd1 : seen_r;

  // Last coefficient of a block compares only its left neighbour
  assign end_peak = (seen_p == SEEN_TWO) && win_newer_p && (newer_p > older_p);

  assign blk.blk_done = item_fire && item.block_end;
  assign blk.blk_peak = peak_r || mid_peak || end_peak;

  always_comb begin
    phase_nxt = phase_r;
    seen_nxt  = seen_r;
    peak_nxt  = peak_r;
    if (item_fire) begin
      if (item.block_end) begin
        phase_nxt = 1'b0;
        seen_nxt  = SEEN_NONE;
        peak_nxt  = 1'b0;
      end else begin
        phase_nxt = !phase_r;
        seen_nxt  = seen_p;
        peak_nxt  = peak_r || mid_peak;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      seen_r  <= SEEN_NONE;
      peak_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      seen_r  <= seen_nxt;
      peak_r  <= peak_nxt;
    end
  end

  // Hold the even average and the two newest coefficients
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      even_r  <= '0;
      older_r <= '0;
      newer_r <= '0;
    end else if (item_fire) begin
      if (!phase_r) begin
        even_r <= item.avg;
      end
      older_r <= older_p;
      newer_r <= newer_p;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) seen_r != 2'd3)
    else $error("coefficient count beyond two");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (item_fire && item.block_end) |=> (!phase_r && !peak_r && seen_r == SEEN_NONE))
    else $error("block state not cleared at block end");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (seen_r == SEEN_NONE) |-> !peak_r)
    else $error("peak flagged without coefficients");

endmodule

// File: src/htt_verdict.sv
module htt_verdict (
  input  logic                           clk,
  input  logic                           rst_n,
  input  htt_pkg::htt_cfg_t              cfg,
  input  htt_pkg::htt_blk_t              blk,
  output logic                           out_hold,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [htt_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import htt_pkg::*;

  logic [COOL_W-1:0] cool_r, cool_nxt;
  logic              pend_r, pend_nxt;
  logic [BSF_W-1:0]  bsf_r, bsf_nxt, bsf_inc;
  logic              out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic              tap, in_window;

  assign tap       = (cool_r == '0) && blk.blk_peak;
  assign bsf_inc   = (pend_r && (bsf_r != BSF_MAX)) ? bsf_r + BSF_W'(1) : bsf_r;
  assign in_window = bsf_inc <= BSF_W'(cfg.double_window);

  // Block verdict: cooldown, then pair taps into single or double; a startup write reloads the cooldown
  always_comb begin
    cool_nxt = cool_r;
    pend_nxt = pend_r;
    bsf_nxt  = bsf_r;
    kind_nxt = KIND_NONE;
    if (blk.blk_done) begin
      if (tap) begin
        cool_nxt = cfg.cooldown_blocks;
      end else if (cool_r != '0) begin
        cool_nxt = cool_r - COOL_W'(1);
      end
      bsf_nxt = bsf_inc;
      if (tap) begin
        bsf_nxt = '0;
        if (pend_r && in_window) begin
          kind_nxt = KIND_DOUBLE;
          pend_nxt = 1'b0;
        end else if (pend_r) begin
          kind_nxt = KIND_SINGLE;
        end else begin
          pend_nxt = 1'b1;
        end
      end else if (pend_r && !in_window) begin
        kind_nxt = KIND_SINGLE;
        pend_nxt = 1'b0;
        bsf_nxt  = '0;
      end
    end
    if (cfg.startup_load) begin
      cool_nxt = cfg.startup_cooldown;
    end
  end

  // Result register: fill on block end, drain on transfer
  assign out_hold = out_valid_r && !out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (blk.blk_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cool_r      <= STARTUP_RST;
      pend_r      <= 1'b0;
      bsf_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cool_r      <= cool_nxt;
      pend_r      <= pend_nxt;
      bsf_r       <= bsf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (blk.blk_done) begin
      kind_r <= kind_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(kind_r);

  assert property (@(posedge clk) disable iff (!rst_n) !pend_r |-> (bsf_r == '0))
    else $error("elapsed-block count running without a pending tap");
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid_r |-> (kind_r == KIND_NONE || kind_r == KIND_SINGLE ||
                                    kind_r == KIND_DOUBLE))
    else $error("undefined verdict code");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (blk.blk_done && kind_nxt == KIND_DOUBLE) |=> !pend_r)
    else $error("double tap left a first tap pending");
  assert property (@(posedge clk) disable iff (!rst_n) blk.blk_done |-> !out_hold)
    else $error("result register overwritten");

endmodule

// File: src/haar_transient_tap_detector_top.sv
// Channel  Direction  Payload (low bit up)
// in_      slave      tdata: mic_a_sample, mic_b_sample; tlast: block_end
// out_     master     tdata: tap_kind (zero padded to a byte)
// cfg_     slave      index: register number; data: register value
//
// One sample pair is taken every cycle unless a held block-end pair stalls
// the input; a verdict leaves through the input register, then the result register.
// The rate is set by the single compare path from the input register to
// the result register; only a block-end pair waits while a verdict is held.
// rst_n is synchronous and active low; configuration writes always complete.
module haar_transient_tap_detector_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: mic_a_sample, mic_b_sample
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [htt_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                           in_tlast,
  // out_tdata: tap_kind
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [htt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [htt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [htt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import htt_pkg::*;

  logic signed [THR_W-1:0] thr_low_r, thr_high_r;
  logic [COOL_W-1:0]       cooldown_r;
  logic [WIN_W-1:0]        window_r;
  logic                    cfg_xfer, startup_load;
  htt_cfg_t                cfg;
  htt_item_t               item;
  logic                    item_fire;
  logic                    out_hold;
  htt_blk_t                blk;

  assign cfg_ready    = 1'b1;
  assign cfg_xfer     = cfg_valid && cfg_ready;
  assign startup_load = cfg_xfer && (cfg_index == REG_STARTUP_COOL);

  // Configuration register file; a startup write loads the cooldown directly
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_low_r  <= THR_LOW_RST;
      thr_high_r <= THR_HIGH_RST;
      cooldown_r <= COOLDOWN_RST;
      window_r   <= WINDOW_RST;
    end else if (cfg_xfer) begin
      unique case (cfg_index)
        REG_THR_LOW:       thr_low_r  <= cfg_data;
        REG_THR_HIGH:      thr_high_r <= cfg_data;
        REG_COOLDOWN:      cooldown_r <= cfg_data[COOL_W-1:0];
        REG_DOUBLE_WINDOW: window_r   <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.thr_low          = thr_low_r;
  assign cfg.thr_high         = thr_high_r;
  assign cfg.cooldown_blocks  = cooldown_r;
  assign cfg.double_window    = window_r;
  assign cfg.startup_load     = startup_load;
  assign cfg.startup_cooldown = cfg_data[COOL_W-1:0];

  htt_avg_stage u_avg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_hold  (out_hold),
    .item      (item),
    .item_fire (item_fire)
  );

  htt_peak u_peak (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .item      (item),
    .item_fire (item_fire),
    .blk       (blk)
  );

  htt_verdict u_verdict (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .blk        (blk),
    .out_hold   (out_hold),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
